// ===== hw/rtl/drd_pkg.sv =====
package drd_pkg;

    localparam int ATTR_W       = 24;
    localparam int POS_W        = 7;
    localparam int CLS_W        = 7;
    localparam int BOX_W        = 17;
    localparam int SCORE_W      = 24;
    localparam int CNT_W        = 8;
    localparam int DIM_W        = 14;
    localparam int THR_W        = 13;
    localparam int FRAC_BITS    = 12;
    localparam int CLASS_OFFSET = 5;
    localparam int MIN_ATTRS    = 6;
    localparam int MAX_ATTRS    = 128;
    localparam int NUM_BOX      = 4;
    localparam int BOX_IDX_W    = $clog2(NUM_BOX);
    localparam int OBJ_POS      = NUM_BOX;

    // scaling datapath widths
    localparam int NUM_W        = ATTR_W + 2;
    localparam int PROD_W       = NUM_W + DIM_W + 1;
    localparam int SCALE_W      = NUM_W;
    localparam int SPROD_W      = 2 * ATTR_W;
    localparam int BOX_LIM      = 2 ** (BOX_W - 1);

    // row queue
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = $clog2(QDEPTH + 1);

    // register file
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 14;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTR_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJ_THR      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THR    = 3'd4;

    localparam logic [CNT_W-1:0] RST_ATTR_COUNT = 8'd85;
    localparam logic [DIM_W-1:0] RST_IMAGE_DIM  = 14'd640;
    localparam logic [THR_W-1:0] RST_THR        = 13'd1024;

    typedef logic signed [ATTR_W-1:0] t_attr;

    typedef struct packed {
        t_attr              cx;
        t_attr              cy;
        t_attr              w;
        t_attr              h;
        t_attr              obj;
        t_attr              best;
        logic [CLS_W-1:0]   cls;
        logic               found;
    } t_row_rec;

    typedef struct packed {
        logic [DIM_W-1:0]   image_width;
        logic [DIM_W-1:0]   image_height;
        logic [THR_W-1:0]   object_threshold;
        logic [THR_W-1:0]   score_threshold;
    } t_scale_cfg;

endpackage

// ===== hw/rtl/drd_attr_if.sv =====
interface drd_attr_if;
    import drd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [ATTR_W-1:0]   attr_value;

    modport source (output valid, output attr_value, input ready);
    modport sink   (input valid, input attr_value, output ready);
endinterface

// ===== hw/rtl/drd_det_if.sv =====
interface drd_det_if;
    import drd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [BOX_W-1:0]    box_x;
    logic signed [BOX_W-1:0]    box_y;
    logic signed [BOX_W-1:0]    box_w;
    logic signed [BOX_W-1:0]    box_h;
    logic [SCORE_W-1:0]         score;
    logic [CLS_W-1:0]           class_index;

    modport source (output valid, output box_x, output box_y, output box_w, output box_h,
                    output score, output class_index, input ready);
    modport sink   (input valid, input box_x, input box_y, input box_w, input box_h,
                    input score, input class_index, output ready);
endinterface

// ===== hw/rtl/drd_front.sv =====
module drd_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    drd_attr_if.sink                    i_attr,
    input  logic [drd_pkg::CNT_W-1:0]   i_attr_count,
    input  logic                        i_q_full,
    output logic                        o_push,
    output drd_pkg::t_row_rec           o_rec
);
    import drd_pkg::*;

    logic [POS_W-1:0]   r_pos;
    t_attr              r_box [NUM_BOX];
    t_attr              r_obj;
    t_attr              r_best;
    logic [CLS_W-1:0]   r_cls;
    logic               r_found;

    t_attr              n_box [NUM_BOX];
    t_attr              n_obj;
    t_attr              n_best;
    logic [CLS_W-1:0]   n_cls;
    logic               n_found;

    t_attr              v;
    logic               accept;
    logic               row_end;
    logic [CNT_W-1:0]   count;

    assign i_attr.ready = !i_q_full;
    assign accept       = i_attr.valid && !i_q_full;
    assign v            = i_attr.attr_value;

    always_comb begin
        if (i_attr_count < CNT_W'(MIN_ATTRS)) begin
            count = CNT_W'(MIN_ATTRS);
        end else if (int'(i_attr_count) > MAX_ATTRS) begin
            count = CNT_W'(MAX_ATTRS);
        end else begin
            count = i_attr_count;
        end
        row_end = ((CNT_W+1)'(r_pos) + (CNT_W+1)'(1)) >= (CNT_W+1)'(count);
    end

    // route the beat to its slot in the row
    always_comb begin
        n_box   = r_box;
        n_obj   = r_obj;
        n_best  = r_best;
        n_cls   = r_cls;
        n_found = r_found;
        if (r_pos < POS_W'(NUM_BOX)) begin
            n_box[r_pos[BOX_IDX_W-1:0]] = v;
        end else if (r_pos == POS_W'(OBJ_POS)) begin
            n_obj = v;
        end else if (v > r_best) begin
            n_best  = v;
            n_cls   = CLS_W'(r_pos - POS_W'(CLASS_OFFSET));
            n_found = 1'b1;
        end
    end

    assign o_push      = accept && row_end;
    assign o_rec.cx    = n_box[0];
    assign o_rec.cy    = n_box[1];
    assign o_rec.w     = n_box[2];
    assign o_rec.h     = n_box[3];
    assign o_rec.obj   = n_obj;
    assign o_rec.best  = n_best;
    assign o_rec.cls   = n_cls;
    assign o_rec.found = n_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_pos   <= '0;
            for (int i = 0; i < NUM_BOX; i++) begin
                r_box[i] <= '0;
            end
            r_obj   <= '0;
            r_best  <= '0;
            r_cls   <= '0;
            r_found <= 1'b0;
        end else if (accept) begin
            r_pos   <= r_pos + 1'b1;
            r_box   <= n_box;
            r_obj   <= n_obj;
            r_best  <= n_best;
            r_cls   <= n_cls;
            r_found <= n_found;
        end
    end

`ifndef SYNTH
    a_row_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> (r_pos == '0 && !r_found && r_best == '0))
        else $error("row state not cleared after row end");
`endif

endmodule

// ===== hw/rtl/drd_queue.sv =====
module drd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  drd_pkg::t_row_rec   i_data,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_empty,
    output drd_pkg::t_row_rec   o_head
);
    import drd_pkg::*;

    t_row_rec           r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr;
    logic [QPTR_W-1:0]  r_rd;
    logic [QCNT_W-1:0]  r_count;

    assign o_full  = r_count == QCNT_W'(QDEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("row queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("row queue underflow");
`endif

endmodule

// ===== hw/rtl/drd_back.sv =====
module drd_back #(
    parameter int MODEL_SIZE = 640
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  drd_pkg::t_row_rec   i_head,
    input  logic                i_empty,
    output logic                o_pop,
    input  drd_pkg::t_scale_cfg i_cfg,
    drd_det_if.source           o_det
);
    import drd_pkg::*;

    localparam int SHIFT_L = $clog2(MODEL_SIZE);
    localparam int RECIP_K = SCALE_W + SHIFT_L;
    localparam int R_W     = SCALE_W + 1;
    localparam int Q_W     = SCALE_W + R_W;
    localparam logic [R_W-1:0] RECIP =
        R_W'(((64'd1 << RECIP_K) + 64'(MODEL_SIZE) - 64'd1) / 64'(MODEL_SIZE));

    logic                       adv;

    // stage a: products
    logic                       r_va;
    logic signed [PROD_W-1:0]   r_p [NUM_BOX];
    logic signed [SPROD_W-1:0]  r_sprod;
    logic                       r_found_a;
    logic                       r_objok_a;
    logic [CLS_W-1:0]           r_cls_a;

    // stage b: magnitudes and decision
    logic                       r_vb;
    logic [SCALE_W-1:0]         r_mag [NUM_BOX];
    logic                       r_neg_b [NUM_BOX];
    logic [SCORE_W-1:0]         r_score_b;
    logic [CLS_W-1:0]           r_cls_b;

    // stage c: quotients
    logic                       r_vc;
    logic [SCALE_W-1:0]         r_q [NUM_BOX];
    logic                       r_neg_c [NUM_BOX];
    logic [SCORE_W-1:0]         r_score_c;
    logic [CLS_W-1:0]           r_cls_c;

    // output register
    logic                       r_out_valid;
    logic [BOX_W-1:0]           r_box_o [NUM_BOX];
    logic [SCORE_W-1:0]         r_score_o;
    logic [CLS_W-1:0]           r_cls_o;

    logic signed [NUM_W-1:0]    num [NUM_BOX];
    logic [DIM_W-1:0]           dim [NUM_BOX];
    logic [PROD_W-1:0]          absv [NUM_BOX];
    logic [SCALE_W-1:0]         mag [NUM_BOX];
    logic [Q_W-1:0]             qp [NUM_BOX];
    logic [BOX_W-1:0]           sat [NUM_BOX];
    logic                       emit;

    assign adv   = !r_out_valid || o_det.ready;
    assign o_pop = adv && !i_empty;

    always_comb begin
        num[0] = (NUM_W'($signed(i_head.cx)) <<< 1) - NUM_W'($signed(i_head.w));
        num[1] = (NUM_W'($signed(i_head.cy)) <<< 1) - NUM_W'($signed(i_head.h));
        num[2] = NUM_W'($signed(i_head.w));
        num[3] = NUM_W'($signed(i_head.h));
        dim[0] = i_cfg.image_width;
        dim[1] = i_cfg.image_height;
        dim[2] = i_cfg.image_width;
        dim[3] = i_cfg.image_height;
    end

    always_comb begin
        emit = r_va && r_found_a && r_objok_a &&
               (r_sprod >= $signed(SPROD_W'({i_cfg.score_threshold, FRAC_BITS'(0)})));
        for (int i = 0; i < NUM_BOX; i++) begin
            absv[i] = r_p[i][PROD_W-1] ? PROD_W'(-r_p[i]) : PROD_W'(r_p[i]);
            // center lanes carry twice the numerator
            mag[i]  = SCALE_W'(absv[i] >> ((i < 2) ? (FRAC_BITS + 1) : FRAC_BITS));
            qp[i]   = r_mag[i] * RECIP;
            if (r_neg_c[i]) begin
                sat[i] = (r_q[i] >= SCALE_W'(BOX_LIM)) ? BOX_W'(BOX_LIM)
                                                       : -BOX_W'(r_q[i]);
            end else begin
                sat[i] = (r_q[i] >= SCALE_W'(BOX_LIM)) ? BOX_W'(BOX_LIM - 1)
                                                       : BOX_W'(r_q[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va        <= 1'b0;
            r_vb        <= 1'b0;
            r_vc        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_va        <= !i_empty;
            r_vb        <= emit;
            r_vc        <= r_vb;
            r_out_valid <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < NUM_BOX; i++) begin
                r_p[i]     <= num[i] * $signed({1'b0, dim[i]});
                r_mag[i]   <= mag[i];
                r_neg_b[i] <= r_p[i][PROD_W-1];
                r_q[i]     <= SCALE_W'(qp[i] >> RECIP_K);
                r_neg_c[i] <= r_neg_b[i];
                r_box_o[i] <= sat[i];
            end
            r_sprod   <= $signed(i_head.obj) * $signed(i_head.best);
            r_found_a <= i_head.found;
            r_objok_a <= $signed(i_head.obj) >=
                         $signed(ATTR_W'({1'b0, i_cfg.object_threshold}));
            r_cls_a   <= i_head.cls;

            r_score_b <= (|r_sprod[SPROD_W-1:SCORE_W+FRAC_BITS]) ? '1
                         : r_sprod[SCORE_W+FRAC_BITS-1:FRAC_BITS];
            r_cls_b   <= r_cls_a;

            r_score_c <= r_score_b;
            r_cls_c   <= r_cls_b;

            r_score_o <= r_score_c;
            r_cls_o   <= r_cls_c;
        end
    end

    assign o_det.valid       = r_out_valid;
    assign o_det.box_x       = r_box_o[0];
    assign o_det.box_y       = r_box_o[1];
    assign o_det.box_w       = r_box_o[2];
    assign o_det.box_h       = r_box_o[3];
    assign o_det.score       = r_score_o;
    assign o_det.class_index = r_cls_o;

`ifndef SYNTH
    a_out_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_vc))
        else $error("detection beat without a scaled row behind it");
`endif

endmodule

// ===== hw/rtl/detector_row_decode.sv =====
// a row goes through the row queue, stages a, b, c and the output register to its detection beat
// throughput: one attribute beat per cycle while the queue is not full; the 4-stage scaling
// pipeline takes a row per cycle unless the output stalls; the 2-entry row queue lets the
// attribute front end run while the detection output stalls
// reset: synchronous, active low; clears row state, queue, pipeline valids and loads register defaults
module detector_row_decode #(
    parameter int MODEL_SIZE = 640
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    drd_attr_if.sink                        i_attr,
    drd_det_if.source                       o_det,
    input  logic                            i_cfg_we,
    input  logic [drd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [drd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import drd_pkg::*;

    logic [CNT_W-1:0]   r_attr_count;
    t_scale_cfg         r_cfg;

    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    t_row_rec           q_in;
    t_row_rec           q_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr_count           <= RST_ATTR_COUNT;
            r_cfg.image_width      <= RST_IMAGE_DIM;
            r_cfg.image_height     <= RST_IMAGE_DIM;
            r_cfg.object_threshold <= RST_THR;
            r_cfg.score_threshold  <= RST_THR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ATTR_COUNT:   r_attr_count           <= i_cfg_data[CNT_W-1:0];
                CFG_IMAGE_WIDTH:  r_cfg.image_width      <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: r_cfg.image_height     <= i_cfg_data[DIM_W-1:0];
                CFG_OBJ_THR:      r_cfg.object_threshold <= i_cfg_data[THR_W-1:0];
                CFG_SCORE_THR:    r_cfg.score_threshold  <= i_cfg_data[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    drd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_attr       (i_attr),
        .i_attr_count (r_attr_count),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_rec        (q_in)
    );

    drd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    drd_back #(
        .MODEL_SIZE (MODEL_SIZE)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .i_cfg   (r_cfg),
        .o_det   (o_det)
    );

endmodule
